// ===== hw/rtl/sstsum_pkg.sv =====
// Package for the shortest target-sum segment core.
// Holds shared widths, the hash multiplier, payload structs and state enums.
package sstsum_pkg;

  localparam int unsigned MAX_ITEMS_DEF  = 1024;
  localparam int unsigned HASH_SLOTS_DEF = 2048;

  localparam int unsigned SUM_W      = 48;
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned LEN_OUT_W  = 11;
  localparam int unsigned EPOCH_W    = 8;
  localparam int unsigned MUL_W      = 32;

  localparam logic [63:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;

  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_req_t;

  typedef struct packed {
    logic                 found;
    logic [POS_W-1:0]     start_index;
    logic [POS_W-1:0]     end_index;
    logic [LEN_OUT_W-1:0] seg_length;
    logic                 overflow;
  } out_req_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_SEED,
    S_IDLE,
    S_DIFF,
    S_HASH_L,
    S_WAIT_L,
    S_LRD,
    S_LCHK,
    S_BEST,
    S_HASH_P,
    S_WAIT_P,
    S_PRD,
    S_PCHK,
    S_NEXT,
    S_OUT
  } seq_state_e;

  typedef enum logic [3:0] {
    H_IDLE,
    H_M0,
    H_M1,
    H_M2,
    H_ACC,
    H_QE,
    H_QN,
    H_REM,
    H_FIX,
    H_DONE
  } hash_state_e;

endpackage

// ===== hw/rtl/sstsum_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; it uses nothing from the package.
module sstsum_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sstsum_hash.sv =====
// Home-slot hash unit built around one shared 32x32 multiplier.
// Uses sstsum_pkg for the key width, the hash constant and its state enum.
module sstsum_hash #(
  parameter int unsigned HASH_SLOTS = sstsum_pkg::HASH_SLOTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [sstsum_pkg::SUM_W-1:0]     key_i,
  output logic                             done_o,
  output logic [$clog2(HASH_SLOTS)-1:0]    slot_o
);

  localparam int unsigned AW = $clog2(HASH_SLOTS);
  localparam int unsigned RW = AW + 1;
  localparam int unsigned MW = sstsum_pkg::MUL_W;
  localparam int unsigned SW = sstsum_pkg::SUM_W;

  localparam logic [MW-1:0] RECIP   = MW'((64'd1 << 32) / HASH_SLOTS);
  localparam logic [MW-1:0] SLOTS_M = MW'(HASH_SLOTS);
  localparam logic [RW-1:0] SLOTS_R = RW'(HASH_SLOTS);
  localparam logic [MW-1:0] MULT_LO = sstsum_pkg::HASH_MULT[31:0];
  localparam logic [MW-1:0] MULT_HI = sstsum_pkg::HASH_MULT[63:32];

  sstsum_pkg::hash_state_e state_q, state_d;

  logic [SW-1:0]   key_q;
  logic [2*MW-1:0] prod_q;
  logic [MW-1:0]   acc_q;
  logic [RW-1:0]   rem_q;
  logic [AW-1:0]   slot_q;

  logic [MW-1:0]   mul_a, mul_b;
  logic [2*MW-1:0] mul_p;

  always_comb begin
    state_d = state_q;
    case (state_q)
      sstsum_pkg::H_IDLE: begin
        if (start_i) begin
          state_d = sstsum_pkg::H_M0;
        end
      end
      sstsum_pkg::H_M0:   state_d = sstsum_pkg::H_M1;
      sstsum_pkg::H_M1:   state_d = sstsum_pkg::H_M2;
      sstsum_pkg::H_M2:   state_d = sstsum_pkg::H_ACC;
      sstsum_pkg::H_ACC:  state_d = sstsum_pkg::H_QE;
      sstsum_pkg::H_QE:   state_d = sstsum_pkg::H_QN;
      sstsum_pkg::H_QN:   state_d = sstsum_pkg::H_REM;
      sstsum_pkg::H_REM:  state_d = sstsum_pkg::H_FIX;
      sstsum_pkg::H_FIX:  state_d = sstsum_pkg::H_DONE;
      sstsum_pkg::H_DONE: state_d = sstsum_pkg::H_IDLE;
      default:            state_d = sstsum_pkg::H_IDLE;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      sstsum_pkg::H_M0: begin
        mul_a = key_q[MW-1:0];
        mul_b = MULT_LO;
      end
      sstsum_pkg::H_M1: begin
        mul_a = key_q[MW-1:0];
        mul_b = MULT_HI;
      end
      sstsum_pkg::H_M2: begin
        mul_a = MW'(key_q[SW-1:MW]);
        mul_b = MULT_LO;
      end
      sstsum_pkg::H_QE: begin
        mul_a = acc_q;
        mul_b = RECIP;
      end
      sstsum_pkg::H_QN: begin
        mul_a = prod_q[2*MW-1:MW];
        mul_b = SLOTS_M;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  assign done_o = (state_q == sstsum_pkg::H_DONE);
  assign slot_o = slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sstsum_pkg::H_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      sstsum_pkg::H_IDLE: begin
        if (start_i) begin
          key_q <= key_i;
        end
      end
      sstsum_pkg::H_M0: begin
        prod_q <= mul_p;
      end
      sstsum_pkg::H_M1: begin
        acc_q  <= prod_q[2*MW-1:MW];
        prod_q <= mul_p;
      end
      sstsum_pkg::H_M2: begin
        acc_q  <= acc_q + prod_q[MW-1:0];
        prod_q <= mul_p;
      end
      sstsum_pkg::H_ACC: begin
        acc_q <= acc_q + prod_q[MW-1:0];
      end
      sstsum_pkg::H_QE: begin
        prod_q <= mul_p;
      end
      sstsum_pkg::H_QN: begin
        prod_q <= mul_p;
      end
      sstsum_pkg::H_REM: begin
        rem_q <= RW'(acc_q - prod_q[MW-1:0]);
      end
      sstsum_pkg::H_FIX: begin
        if (rem_q >= SLOTS_R) begin
          slot_q <= AW'(rem_q - SLOTS_R);
        end else begin
          slot_q <= AW'(rem_q);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/sstsum_seq.sv =====
// Sequencer and datapath: prefix sum, store probing, best segment, result.
// Uses sstsum_pkg; drives the hash unit and the slot RAM of the top level.
module sstsum_seq #(
  parameter int unsigned MAX_ITEMS  = sstsum_pkg::MAX_ITEMS_DEF,
  parameter int unsigned HASH_SLOTS = sstsum_pkg::HASH_SLOTS_DEF,
  parameter int unsigned WORD_W     = sstsum_pkg::EPOCH_W + sstsum_pkg::SUM_W
                                      + $clog2(MAX_ITEMS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  sstsum_pkg::in_req_t           in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output sstsum_pkg::out_req_t          out_req_o,
  input  logic                          cfg_we_i,
  input  logic [sstsum_pkg::SUM_W-1:0]  cfg_wdata_i,
  output logic                          hash_start_o,
  output logic [sstsum_pkg::SUM_W-1:0]  hash_key_o,
  input  logic                          hash_done_i,
  input  logic [$clog2(HASH_SLOTS)-1:0] hash_slot_i,
  output logic                          ram_we_o,
  output logic [$clog2(HASH_SLOTS)-1:0] ram_waddr_o,
  output logic [WORD_W-1:0]             ram_wdata_o,
  output logic                          ram_re_o,
  output logic [$clog2(HASH_SLOTS)-1:0] ram_raddr_o,
  input  logic [WORD_W-1:0]             ram_rdata_i
);

  localparam int unsigned AW     = $clog2(HASH_SLOTS);
  localparam int unsigned SW     = sstsum_pkg::SUM_W;
  localparam int unsigned XW     = sstsum_pkg::SAMPLE_W;
  localparam int unsigned EW     = sstsum_pkg::EPOCH_W;
  localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned IDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned LEN_W  = $clog2(MAX_ITEMS + 2);

  localparam logic [AW-1:0]    SLOT_LAST = AW'(HASH_SLOTS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_ITEMS);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_ITEMS);
  localparam logic [LEN_W-1:0] LEN_NONE  = LEN_W'(MAX_ITEMS + 1);

  sstsum_pkg::seq_state_e state_q, state_d;

  logic [SW-1:0]    target_q;
  logic [SW-1:0]    sum_q;
  logic [SW-1:0]    diff_q;
  logic [CNT_W-1:0] cnt_q;
  logic [LEN_W-1:0] best_len_q;
  logic [IDX_W-1:0] best_start_q;
  logic [IDX_W-1:0] best_end_q;
  logic             ovf_q;
  logic [EW-1:0]    epoch_q;
  logic [AW-1:0]    clr_q;
  logic             out_valid_q;
  sstsum_pkg::out_req_t out_req_q, out_req_d;

  logic             last_q;
  logic [AW-1:0]    pos_q;
  logic [AW-1:0]    probe_q;
  logic [IDX_W-1:0] from_q;

  logic             accept;
  logic             room;
  logic [EW-1:0]    rd_epoch;
  logic [SW-1:0]    rd_key;
  logic [CNT_W-1:0] rd_idx;
  logic             slot_live;
  logic             lk_hit;
  logic             put_here;
  logic             probe_end;
  logic             clr_last;
  logic             out_load;
  logic [AW-1:0]    pos_next;
  logic [LEN_W-1:0] cand_len;
  logic [SW-1:0]    sample_ext;
  logic             found;

  assign rd_idx    = ram_rdata_i[CNT_W-1:0];
  assign rd_key    = ram_rdata_i[CNT_W +: SW];
  assign rd_epoch  = ram_rdata_i[CNT_W + SW +: EW];
  assign slot_live = (rd_epoch == epoch_q);
  assign lk_hit    = slot_live && (rd_key == diff_q);
  assign put_here  = !slot_live || (rd_key == sum_q);
  assign probe_end = (probe_q == SLOT_LAST);
  assign clr_last  = (clr_q == SLOT_LAST);
  assign pos_next  = (pos_q == SLOT_LAST) ? '0 : AW'(pos_q + 1'b1);
  assign room      = (cnt_q < CNT_MAX);
  assign cand_len  = LEN_W'(cnt_q) - LEN_W'(from_q) + LEN_W'(1);
  assign sample_ext = {{(SW - XW){in_req_i.sample[XW-1]}}, in_req_i.sample};
  assign found     = (best_len_q <= LEN_MAX);

  always_comb begin
    state_d = state_q;
    case (state_q)
      sstsum_pkg::S_CLEAR: begin
        if (clr_last) begin
          state_d = sstsum_pkg::S_SEED;
        end
      end
      sstsum_pkg::S_SEED: state_d = sstsum_pkg::S_IDLE;
      sstsum_pkg::S_IDLE: begin
        if (accept) begin
          if (room) begin
            state_d = sstsum_pkg::S_DIFF;
          end else if (in_req_i.last) begin
            state_d = sstsum_pkg::S_OUT;
          end
        end
      end
      sstsum_pkg::S_DIFF:   state_d = sstsum_pkg::S_HASH_L;
      sstsum_pkg::S_HASH_L: state_d = sstsum_pkg::S_WAIT_L;
      sstsum_pkg::S_WAIT_L: begin
        if (hash_done_i) begin
          state_d = sstsum_pkg::S_LRD;
        end
      end
      sstsum_pkg::S_LRD: state_d = sstsum_pkg::S_LCHK;
      sstsum_pkg::S_LCHK: begin
        if (lk_hit) begin
          state_d = sstsum_pkg::S_BEST;
        end else if (!slot_live || probe_end) begin
          state_d = sstsum_pkg::S_HASH_P;
        end else begin
          state_d = sstsum_pkg::S_LRD;
        end
      end
      sstsum_pkg::S_BEST:   state_d = sstsum_pkg::S_HASH_P;
      sstsum_pkg::S_HASH_P: state_d = sstsum_pkg::S_WAIT_P;
      sstsum_pkg::S_WAIT_P: begin
        if (hash_done_i) begin
          state_d = sstsum_pkg::S_PRD;
        end
      end
      sstsum_pkg::S_PRD: state_d = sstsum_pkg::S_PCHK;
      sstsum_pkg::S_PCHK: begin
        if (put_here || probe_end) begin
          state_d = sstsum_pkg::S_NEXT;
        end else begin
          state_d = sstsum_pkg::S_PRD;
        end
      end
      sstsum_pkg::S_NEXT: begin
        if (last_q) begin
          state_d = sstsum_pkg::S_OUT;
        end else begin
          state_d = sstsum_pkg::S_IDLE;
        end
      end
      sstsum_pkg::S_OUT: begin
        if (out_load) begin
          if (epoch_q == sstsum_pkg::EPOCH_LAST) begin
            state_d = sstsum_pkg::S_CLEAR;
          end else begin
            state_d = sstsum_pkg::S_SEED;
          end
        end
      end
      default: state_d = sstsum_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    in_stall_o   = (state_q != sstsum_pkg::S_IDLE);
    hash_start_o = 1'b0;
    hash_key_o   = sum_q;
    ram_we_o     = 1'b0;
    ram_waddr_o  = pos_q;
    ram_wdata_o  = {epoch_q, sum_q, CNT_W'(cnt_q + 1'b1)};
    ram_re_o     = 1'b0;
    ram_raddr_o  = pos_q;
    out_load     = 1'b0;
    case (state_q)
      sstsum_pkg::S_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        ram_wdata_o = '0;
      end
      sstsum_pkg::S_SEED: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = '0;
        ram_wdata_o = {epoch_q, {(SW + CNT_W){1'b0}}};
      end
      sstsum_pkg::S_HASH_L: begin
        hash_start_o = 1'b1;
        hash_key_o   = diff_q;
      end
      sstsum_pkg::S_HASH_P: begin
        hash_start_o = 1'b1;
      end
      sstsum_pkg::S_LRD, sstsum_pkg::S_PRD: begin
        ram_re_o = 1'b1;
      end
      sstsum_pkg::S_PCHK: begin
        ram_we_o = put_here;
      end
      sstsum_pkg::S_OUT: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: begin
      end
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    out_req_d.found       = found;
    out_req_d.start_index = found ? sstsum_pkg::POS_W'(best_start_q) : '0;
    out_req_d.end_index   = found ? sstsum_pkg::POS_W'(best_end_q) : '0;
    out_req_d.seg_length  = found ? sstsum_pkg::LEN_OUT_W'(best_len_q) : '0;
    out_req_d.overflow    = ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sstsum_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= '0;
      sum_q        <= '0;
      cnt_q        <= '0;
      best_len_q   <= LEN_NONE;
      best_start_q <= '0;
      best_end_q   <= '0;
      ovf_q        <= 1'b0;
      epoch_q      <= sstsum_pkg::EPOCH_FIRST;
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        target_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        sstsum_pkg::S_CLEAR: begin
          clr_q <= clr_last ? '0 : AW'(clr_q + 1'b1);
        end
        sstsum_pkg::S_IDLE: begin
          if (accept) begin
            if (room) begin
              sum_q <= sum_q + sample_ext;
            end else begin
              ovf_q <= 1'b1;
            end
          end
        end
        sstsum_pkg::S_BEST: begin
          if (cand_len < best_len_q) begin
            best_len_q   <= cand_len;
            best_start_q <= from_q;
            best_end_q   <= IDX_W'(cnt_q);
          end
        end
        sstsum_pkg::S_NEXT: begin
          cnt_q <= CNT_W'(cnt_q + 1'b1);
        end
        sstsum_pkg::S_OUT: begin
          if (out_load) begin
            sum_q        <= '0;
            cnt_q        <= '0;
            best_len_q   <= LEN_NONE;
            best_start_q <= '0;
            best_end_q   <= '0;
            ovf_q        <= 1'b0;
            if (epoch_q == sstsum_pkg::EPOCH_LAST) begin
              epoch_q <= sstsum_pkg::EPOCH_FIRST;
            end else begin
              epoch_q <= EW'(epoch_q + 1'b1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_req_q <= out_req_d;
    end
    case (state_q)
      sstsum_pkg::S_IDLE: begin
        if (accept) begin
          last_q <= in_req_i.last;
        end
      end
      sstsum_pkg::S_DIFF: begin
        diff_q <= sum_q - target_q;
      end
      sstsum_pkg::S_WAIT_L, sstsum_pkg::S_WAIT_P: begin
        if (hash_done_i) begin
          pos_q   <= hash_slot_i;
          probe_q <= '0;
        end
      end
      sstsum_pkg::S_LCHK: begin
        from_q  <= IDX_W'(rd_idx);
        pos_q   <= pos_next;
        probe_q <= AW'(probe_q + 1'b1);
      end
      sstsum_pkg::S_PCHK: begin
        pos_q   <= pos_next;
        probe_q <= AW'(probe_q + 1'b1);
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule

// ===== hw/rtl/shortest_subarray_with_target_sum_core.sv =====
// Top level of the shortest target-sum segment core: sequencer, hash unit, slot RAM.
// Each sample runs two hashes on the shared multiplier, one for the difference lookup
// and one for the prefix-sum store, each followed by probes of the slot RAM; a hit adds
// a best-segment check. A last sample adds the result and the store reseed, and every
// 255th sequence adds a sweep of the slot RAM. After reset the slot RAM is swept before
// the first sample is taken; the target register resets to zero. Uses sstsum_pkg.
module shortest_subarray_with_target_sum_core #(
  parameter int unsigned MAX_ITEMS  = sstsum_pkg::MAX_ITEMS_DEF,
  parameter int unsigned HASH_SLOTS = sstsum_pkg::HASH_SLOTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  sstsum_pkg::in_req_t          in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output sstsum_pkg::out_req_t         out_req_o,
  input  logic                         cfg_we_i,
  input  logic [sstsum_pkg::SUM_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW     = $clog2(HASH_SLOTS);
  localparam int unsigned WORD_W = sstsum_pkg::EPOCH_W + sstsum_pkg::SUM_W
                                   + $clog2(MAX_ITEMS + 1);

  logic                         hash_start;
  logic [sstsum_pkg::SUM_W-1:0] hash_key;
  logic                         hash_done;
  logic [AW-1:0]                hash_slot;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [WORD_W-1:0]            ram_wdata;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [WORD_W-1:0]            ram_rdata;

  sstsum_seq #(
    .MAX_ITEMS  (MAX_ITEMS),
    .HASH_SLOTS (HASH_SLOTS),
    .WORD_W     (WORD_W)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_req_i     (in_req_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_req_o    (out_req_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .hash_start_o (hash_start),
    .hash_key_o   (hash_key),
    .hash_done_i  (hash_done),
    .hash_slot_i  (hash_slot),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  sstsum_hash #(
    .HASH_SLOTS (HASH_SLOTS)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (hash_key),
    .done_o  (hash_done),
    .slot_o  (hash_slot)
  );

  sstsum_ram #(
    .WIDTH (WORD_W),
    .DEPTH (HASH_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
